[sv/detect_triggered_power_sequencer_top_assert.svh]
// ----------------------------------------------------------------------------
// Detect-triggered power sequencer assertion macros
// Clocked checks on clk, held off while rst is high.
// ----------------------------------------------------------------------------
`ifndef DETECT_TRIGGERED_POWER_SEQUENCER_TOP_ASSERT_SVH
`define DETECT_TRIGGERED_POWER_SEQUENCER_TOP_ASSERT_SVH

// Antecedent holds at an edge, consequent holds at the next edge.
`define DTPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Antecedent and consequent hold at the same edge.
`define DTPS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

[sv/dtps_pkg.sv]
// ----------------------------------------------------------------------------
// dtps_pkg
// Shared payload, configuration types and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package dtps_pkg;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int DELAY_REG_W = 64;
  localparam int GATE_W      = 4;
  localparam int COUNT_W     = 3;
  localparam int POWER_W     = 4;
  localparam int START_CNT_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_ON_DELAYS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_DELAYS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PLAY_GATE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_COUNT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_DETECT = 3'd4;

  localparam logic [COUNT_W-1:0] OUTPUT_COUNT_RST = 3'd4;

  typedef struct packed {
    logic ms_tick;
    logic detect_level;
    logic mute_valid;
    logic mute_value;
  } item_t;

  typedef struct packed {
    logic [POWER_W-1:0] power_outputs;
    logic               busy_res;
    logic               detect_status;
  } result_t;

  typedef struct packed {
    logic [DELAY_REG_W-1:0] on_delays;
    logic [DELAY_REG_W-1:0] off_delays;
    logic [GATE_W-1:0]      play_gate_mask;
    logic [COUNT_W-1:0]     output_count;
    logic                   invert_detect;
  } cfg_t;

endpackage

`default_nettype wire

[sv/detect_triggered_power_sequencer_top.sv]
// Path: an accepted item passes through the input register, then the result register,
//   before its result turns valid and can be taken.
// Throughput: one item per cycle while the result side keeps taking; the single-pass
//   update of the sequencer state between the two registers sets this rate.
// Reset: synchronous, active high; clears all sequencer state, both stages, and
//   the config registers (output count resets to 4, the rest to zero).
// ----------------------------------------------------------------------------
// detect_triggered_power_sequencer_top
// Detect- and mute-triggered power-up/power-down sequencer for four outputs.
// ----------------------------------------------------------------------------
`default_nettype none

`include "detect_triggered_power_sequencer_top_assert.svh"

module detect_triggered_power_sequencer_top #(
  parameter int NUM_OUTPUTS    = 4,
  parameter int DELAY_BITS     = 16,
  parameter int START_DELAY_MS = 10
) (
  input  logic                            clk,
  input  logic                            rst,
  // item channel
  input  logic                            item_valid,
  output logic                            item_ready,
  input  dtps_pkg::item_t                 item,
  // result channel
  output logic                            result_valid,
  input  logic                            result_ready,
  output dtps_pkg::result_t               result,
  // configuration channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dtps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dtps_pkg::CFG_DATA_W-1:0] cfg_data
);

  dtps_pkg::cfg_t    cfg;
  dtps_pkg::item_t   held;
  dtps_pkg::result_t core_result;
  logic              in_full;
  logic              out_space;
  logic              take;

  // Advance the held item through the core whenever the result register
  // can take its result in the same edge.
  assign take = in_full && out_space;

  // Config registers; user must send writes only while block is idle (unenforced).
  dtps_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register: accept a new item while empty or when the held one moves on.
  dtps_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .take       (take),
    .full       (in_full),
    .held       (held)
  );

  // Sequencer state and the one-pass update; state commits only on take.
  dtps_core #(
    .NUM_OUTPUTS    (NUM_OUTPUTS),
    .DELAY_BITS     (DELAY_BITS),
    .START_DELAY_MS (START_DELAY_MS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (take),
    .item    (held),
    .cfg     (cfg),
    .result  (core_result)
  );

  // Result register: hold a finished transaction while the consumer stalls.
  dtps_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .push         (take),
    .data         (core_result),
    .space        (out_space),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // Every processed item yields exactly one result on the next edge.
  `DTPS_ASSERT_NEXT(a_take_gives_result, take, result_valid, "processed item lost its result")
  // An accepted transaction lands in the input register.
  `DTPS_ASSERT_NEXT(a_accept_fills_in, item_valid && item_ready, in_full, "accepted item dropped")
  // A stalled result must block the core from overwriting it.
  `DTPS_ASSERT_SAME(a_stall_blocks_core, result_valid && !result_ready, !take,
                    "core advanced over a stalled result")

endmodule

`default_nettype wire

[sv/dtps_cfg_regs.sv]
// ----------------------------------------------------------------------------
// dtps_cfg_regs
// Configuration register file written through a valid/ready channel.
// ----------------------------------------------------------------------------
`default_nettype none

module dtps_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dtps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dtps_pkg::CFG_DATA_W-1:0]     cfg_data,
  output dtps_pkg::cfg_t                      cfg
);

  dtps_pkg::cfg_t cfg_q;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.on_delays      <= '0;
      cfg_q.off_delays     <= '0;
      cfg_q.play_gate_mask <= '0;
      cfg_q.output_count   <= dtps_pkg::OUTPUT_COUNT_RST;
      cfg_q.invert_detect  <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        dtps_pkg::CFG_ON_DELAYS: begin
          cfg_q.on_delays <= cfg_data[dtps_pkg::DELAY_REG_W-1:0];
        end
        dtps_pkg::CFG_OFF_DELAYS: begin
          cfg_q.off_delays <= cfg_data[dtps_pkg::DELAY_REG_W-1:0];
        end
        dtps_pkg::CFG_PLAY_GATE: begin
          cfg_q.play_gate_mask <= cfg_data[dtps_pkg::GATE_W-1:0];
        end
        dtps_pkg::CFG_OUTPUT_COUNT: begin
          cfg_q.output_count <= cfg_data[dtps_pkg::COUNT_W-1:0];
        end
        dtps_pkg::CFG_INVERT_DETECT: begin
          cfg_q.invert_detect <= cfg_data[0];
        end
        default: begin
          // unmapped index: drop the write
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/dtps_in_stage.sv]
// ----------------------------------------------------------------------------
// dtps_in_stage
// Input register: hold one accepted item until the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dtps_in_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  dtps_pkg::item_t     item,
  input  logic                take,
  output logic                full,
  output dtps_pkg::item_t     held
);

  assign item_ready = !full || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (item_ready) begin
      full <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      held <= item;
    end
  end

endmodule

`default_nettype wire

[sv/dtps_core.sv]
// ----------------------------------------------------------------------------
// dtps_core
// Sequencer state and the single-pass update for one item.
// ----------------------------------------------------------------------------
`default_nettype none

module dtps_core #(
  parameter int NUM_OUTPUTS    = 4,
  parameter int DELAY_BITS     = 16,
  parameter int START_DELAY_MS = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  dtps_pkg::item_t   item,
  input  dtps_pkg::cfg_t    cfg,
  output dtps_pkg::result_t result
);

  localparam int IDX_W = $clog2(NUM_OUTPUTS + 1);
  localparam int GW    = (NUM_OUTPUTS > dtps_pkg::GATE_W) ? NUM_OUTPUTS : dtps_pkg::GATE_W;
  localparam logic [dtps_pkg::START_CNT_W-1:0] START_CNT =
    dtps_pkg::START_CNT_W'(START_DELAY_MS);

  logic                            detect_state, detect_state_next;
  logic                            first_done, first_done_next;
  logic                            play_enable, play_enable_next;
  logic [NUM_OUTPUTS-1:0]          levels, levels_next;
  logic                            start_pending, start_pending_next;
  logic [dtps_pkg::START_CNT_W-1:0] start_cnt, start_cnt_next;
  logic                            run_active, run_active_next;
  logic                            run_dir, run_dir_next;
  logic [IDX_W-1:0]                step_idx, step_idx_next;
  logic [DELAY_BITS-1:0]           step_cnt, step_cnt_next;
  logic                            rerun, rerun_next;

  logic                            lvl;
  logic                            arm;
  logic                            run_done;
  logic                            on_lvl;
  logic [IDX_W-1:0]                n;
  logic [GW-1:0]                   gate_ext;

  // Pick delay field i of the on or off register; fields past bit 63 read 0.
  function automatic logic [DELAY_BITS-1:0] delay_for(
    input logic dir, input logic [IDX_W-1:0] i, input dtps_pkg::cfg_t c);
    logic [dtps_pkg::DELAY_REG_W-1:0] src;
    logic [DELAY_BITS-1:0]            res;
    src = dir ? c.on_delays : c.off_delays;
    res = '0;
    for (int k = 0; k < NUM_OUTPUTS; k++) begin
      if (int'(i) == k) begin
        res = DELAY_BITS'(src >> (k * DELAY_BITS));
      end
    end
    return res;
  endfunction

  always_comb begin
    detect_state_next  = detect_state;
    first_done_next    = first_done;
    play_enable_next   = play_enable;
    levels_next        = levels;
    start_pending_next = start_pending;
    start_cnt_next     = start_cnt;
    run_active_next    = run_active;
    run_dir_next       = run_dir;
    step_idx_next      = step_idx;
    step_cnt_next      = step_cnt;
    rerun_next         = rerun;
    arm                = 1'b0;
    run_done           = 1'b0;
    on_lvl             = 1'b1;
    gate_ext           = GW'(cfg.play_gate_mask);
    lvl                = item.detect_level ^ cfg.invert_detect;

    if (int'(cfg.output_count) > NUM_OUTPUTS) begin
      n = IDX_W'(NUM_OUTPUTS);
    end else begin
      n = IDX_W'(cfg.output_count);
    end

    // detect sampling and mute notice
    if (!first_done || (lvl != detect_state)) begin
      first_done_next   = 1'b1;
      detect_state_next = lvl;
      arm               = 1'b1;
    end
    if (item.mute_valid) begin
      play_enable_next = !item.mute_value;
      arm              = 1'b1;
    end
    if (arm && !start_pending) begin
      start_pending_next = 1'b1;
      start_cnt_next     = START_CNT;
    end

    // millisecond tick
    if (item.ms_tick) begin
      if (start_pending_next && (start_cnt_next != '0)) begin
        start_cnt_next = start_cnt_next - dtps_pkg::START_CNT_W'(1);
      end
      if (run_active && (step_cnt != '0)) begin
        step_cnt_next = step_cnt - DELAY_BITS'(1);
      end
    end

    // start timer expiry
    if (start_pending_next && (start_cnt_next == '0)) begin
      start_pending_next = 1'b0;
      if (run_active) begin
        rerun_next = 1'b1;
      end else begin
        rerun_next = 1'b0;
        if (n != '0) begin
          run_active_next = 1'b1;
          run_dir_next    = detect_state_next;
          step_idx_next   = '0;
          step_cnt_next   = delay_for(detect_state_next, '0, cfg);
        end
      end
    end

    // one run step
    if (run_active_next) begin
      if (step_idx_next >= n) begin
        run_done = 1'b1;
      end else if (step_cnt_next == '0) begin
        for (int k = 0; k < NUM_OUTPUTS; k++) begin
          if (run_dir_next) begin
            if (int'(step_idx_next) == k) begin
              on_lvl = gate_ext[k] ? play_enable_next : 1'b1;
              levels_next[k] = on_lvl;
            end
          end else if (int'(n) - 1 - int'(step_idx_next) == k) begin
            levels_next[k] = 1'b0;
          end
        end
        step_idx_next = step_idx_next + IDX_W'(1);
        if (step_idx_next >= n) begin
          run_done = 1'b1;
        end else begin
          step_cnt_next = delay_for(run_dir_next, step_idx_next, cfg);
        end
      end
    end

    // run end, then a queued run starts without acting this item
    if (run_done) begin
      run_active_next = 1'b0;
      if (rerun_next) begin
        rerun_next = 1'b0;
        if (n != '0) begin
          run_active_next = 1'b1;
          run_dir_next    = detect_state_next;
          step_idx_next   = '0;
          step_cnt_next   = delay_for(detect_state_next, '0, cfg);
        end
      end
    end

    result.power_outputs = dtps_pkg::POWER_W'(levels_next);
    result.busy_res      = run_active_next | start_pending_next;
    result.detect_status = detect_state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      detect_state  <= 1'b0;
      first_done    <= 1'b0;
      play_enable   <= 1'b0;
      levels        <= '0;
      start_pending <= 1'b0;
      start_cnt     <= '0;
      run_active    <= 1'b0;
      run_dir       <= 1'b0;
      step_idx      <= '0;
      step_cnt      <= '0;
      rerun         <= 1'b0;
    end else if (advance) begin
      detect_state  <= detect_state_next;
      first_done    <= first_done_next;
      play_enable   <= play_enable_next;
      levels        <= levels_next;
      start_pending <= start_pending_next;
      start_cnt     <= start_cnt_next;
      run_active    <= run_active_next;
      run_dir       <= run_dir_next;
      step_idx      <= step_idx_next;
      step_cnt      <= step_cnt_next;
      rerun         <= rerun_next;
    end
  end

endmodule

`default_nettype wire

[sv/dtps_out_stage.sv]
// ----------------------------------------------------------------------------
// dtps_out_stage
// Result register: hold a result until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module dtps_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  dtps_pkg::result_t   data,
  output logic                space,
  output logic                result_valid,
  input  logic                result_ready,
  output dtps_pkg::result_t   result
);

  assign space = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (space) begin
      result_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (push && space) begin
      result <= data;
    end
  end

endmodule

`default_nettype wire
